### sv/btpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// btpc_pkg: types and fixed constants of the barometric compensation block
// used by the configuration registers, the shared multiply unit and the top level

package btpc_pkg;

	localparam int unsigned RAW_W      = 24;
	localparam int unsigned VAL_W      = 40;
	localparam int unsigned D_W        = 25;
	localparam int unsigned LT_W       = 48;
	localparam int unsigned WORD_W     = 64;
	localparam int unsigned PROD_W     = 128;
	localparam int unsigned SHIFT_W    = 6;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 48;

	// fraction bits of the exact temperature, the stored temperature and the sum
	localparam int unsigned X_FRAC   = 48;
	localparam int unsigned LT_FRAC  = 36;
	localparam int unsigned ACC_FRAC = 32;

	localparam logic [WORD_W-1:0] P_BIAS = 64'd16384;

	localparam logic signed [WORD_W-1:0] VAL_MAX = (64'sd1 <<< (VAL_W - 1)) - 64'sd1;
	localparam logic signed [WORD_W-1:0] VAL_MIN = -(64'sd1 <<< (VAL_W - 1));

	localparam logic OP_TEMP = 1'b0;
	localparam logic OP_PRES = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_TEMP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PMID  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POFF  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PHIGH = 3'd4;

	typedef struct packed {
		logic             operation;
		logic [RAW_W-1:0] raw_sample;
	} in_item_t;

	typedef struct packed {
		logic                    result_kind;
		logic signed [VAL_W-1:0] result_value;
		logic                    saturated;
	} out_item_t;

	typedef struct packed {
		logic        [15:0] t1;
		logic        [15:0] t2;
		logic signed [7:0]  t3;
		logic signed [15:0] p1;
		logic signed [15:0] p2;
		logic signed [7:0]  p3;
		logic signed [7:0]  p4;
		logic        [15:0] p5;
		logic        [15:0] p6;
		logic signed [7:0]  p7;
		logic signed [7:0]  p8;
		logic signed [15:0] p9;
		logic signed [7:0]  p10;
		logic signed [7:0]  p11;
	} coef_t;

	typedef struct packed {
		logic               start;
		logic               neg;
		logic [SHIFT_W-1:0] shift;
		logic [WORD_W-1:0]  a_mag;
		logic [WORD_W-1:0]  b_mag;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic              neg;
		logic [WORD_W-1:0] mag;
	} mul_rsp_t;

endpackage

`default_nettype wire

### sv/btpc_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// btpc_cfg: calibration register file, split into coefficient fields
// depends on btpc_pkg

module btpc_cfg import btpc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output coef_t                 coef
);

	coef_t coef_q;

	assign cfg_ready = 1'b1;
	assign coef      = coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TEMP: begin
					coef_q.t1 <= cfg_data[15:0];
					coef_q.t2 <= cfg_data[31:16];
					coef_q.t3 <= cfg_data[39:32];
				end
				REG_PLIN: begin
					coef_q.p1 <= cfg_data[15:0];
					coef_q.p2 <= cfg_data[31:16];
				end
				REG_PMID: begin
					coef_q.p3 <= cfg_data[7:0];
					coef_q.p4 <= cfg_data[15:8];
					coef_q.p5 <= cfg_data[31:16];
					coef_q.p6 <= cfg_data[47:32];
				end
				REG_POFF: begin
					coef_q.p7 <= cfg_data[7:0];
					coef_q.p8 <= cfg_data[15:8];
					coef_q.p9 <= cfg_data[31:16];
				end
				REG_PHIGH: begin
					coef_q.p10 <= cfg_data[7:0];
					coef_q.p11 <= cfg_data[15:8];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### sv/btpc_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// btpc_mul: shared 64x64 magnitude multiplier with round-half-up shift
// four 32x32 partial products, then a rounding step; depends on btpc_pkg

module btpc_mul import btpc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	typedef enum logic [1:0] {M_IDLE, M_MUL, M_RND, M_DONE} mstate_t;

	localparam int unsigned HALF_W = WORD_W / 2;

	mstate_t             mstate_q;
	logic [1:0]          cnt_q;
	logic [WORD_W-1:0]   a_q;
	logic [WORD_W-1:0]   b_q;
	logic [SHIFT_W-1:0]  sh_q;
	logic                neg_q;
	logic [PROD_W-1:0]   prod_q;
	logic [WORD_W-1:0]   mag_q;

	logic [HALF_W-1:0]   a_half;
	logic [HALF_W-1:0]   b_half;
	logic [WORD_W-1:0]   pp;
	logic [6:0]          pp_ofs;
	logic [PROD_W-1:0]   pp_sh;
	logic [PROD_W-1:0]   rnd_c;
	logic [PROD_W-1:0]   rnd_sum;
	logic [PROD_W-1:0]   rnd_sh;

	// partial product cnt: bit 1 picks the half of a, bit 0 the half of b
	assign a_half  = cnt_q[1] ? a_q[WORD_W-1:HALF_W] : a_q[HALF_W-1:0];
	assign b_half  = cnt_q[0] ? b_q[WORD_W-1:HALF_W] : b_q[HALF_W-1:0];
	assign pp      = WORD_W'(a_half) * WORD_W'(b_half);
	assign pp_ofs  = {cnt_q[1] & cnt_q[0], cnt_q[1] ^ cnt_q[0], 5'b0};
	assign pp_sh   = {{(PROD_W-WORD_W){1'b0}}, pp} << pp_ofs;

	// weight of the highest dropped bit (half a result LSB), zero for no shift
	assign rnd_c   = ({{(PROD_W-1){1'b0}}, 1'b1} << sh_q) >> 1;
	assign rnd_sum = prod_q + rnd_c;
	assign rnd_sh  = rnd_sum >> sh_q;

	assign rsp.done = (mstate_q == M_DONE);
	assign rsp.neg  = neg_q;
	assign rsp.mag  = mag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mstate_q <= M_IDLE;
			cnt_q    <= '0;
		end else begin
			unique case (mstate_q)
				M_IDLE: begin
					cnt_q <= '0;
					if (req.start) begin
						mstate_q <= M_MUL;
					end
				end
				M_MUL: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						mstate_q <= M_RND;
					end
				end
				M_RND:   mstate_q <= M_DONE;
				M_DONE:  mstate_q <= M_IDLE;
				default: mstate_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mstate_q == M_IDLE && req.start) begin
			a_q    <= req.a_mag;
			b_q    <= req.b_mag;
			sh_q   <= req.shift;
			neg_q  <= req.neg;
			prod_q <= '0;
		end else if (mstate_q == M_MUL) begin
			prod_q <= prod_q + pp_sh;
		end else if (mstate_q == M_RND) begin
			mag_q <= rnd_sh[WORD_W-1:0];
		end
	end

endmodule

`default_nettype wire

### sv/baro_temp_pressure_compensation_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Barometric sensor compensation. Each item is a 24-bit raw reading tagged
// as temperature or pressure; temperature gives the linearised value in degrees C
// and keeps it for later pressure items, pressure gives pascal. Results are signed
// fixed point with OUT_FRAC_BITS fraction bits and saturate with a flag. All products
// run through one shared multiplier (four 32x32 partial products plus a rounding
// step) under a microcoded sequencer: a temperature item needs 4 products, a
// pressure item 15. The input is stalled while an item is in work; calibration
// must be written through cfg_* only while idle, which the block does not enforce.

module baro_temp_pressure_compensation_top import btpc_pkg::*; #(
	parameter int unsigned OUT_FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT} state_t;

	typedef enum logic [4:0] {
		S_T_DT3, S_T_X, S_T_LT, S_T_OUT,
		S_P_TSQ, S_P_TCU, S_P_OFF6, S_P_OFF7, S_P_OFF8,
		S_P_LIN2, S_P_LIN3, S_P_LIN4, S_P_KRAW,
		S_P_Q2, S_P_RSQ, S_P_SQR, S_P_CUB1, S_P_CUB2, S_P_OUT
	} step_t;

	typedef enum logic [3:0] {
		A_D, A_K, A_L, A_TSQ, A_P6, A_P7, A_P8, A_P2M, A_P3, A_P4,
		A_P10, A_RAW, A_P11, A_W, A_ACC
	} a_sel_t;

	typedef enum logic [2:0] {B_T3, B_W, B_ONE, B_L, B_TSQ, B_TCU, B_RAW} b_sel_t;

	typedef enum logic [2:0] {DST_W, DST_K, DST_ACC, DST_TSQ, DST_TCU, DST_LT, DST_RES} dst_t;

	typedef enum logic [2:0] {BASE_DST, BASE_ZERO, BASE_T2, BASE_P5, BASE_P1, BASE_P9} base_t;

	typedef struct packed {
		a_sel_t             a_sel;
		b_sel_t             b_sel;
		logic [SHIFT_W-1:0] shift;
		dst_t               dst;
		base_t              base;
		step_t              nxt;
	} ucode_t;

	localparam logic [SHIFT_W-1:0] SH_T_OUT = SHIFT_W'(X_FRAC - OUT_FRAC_BITS);
	localparam logic [SHIFT_W-1:0] SH_P_OUT = SHIFT_W'(ACC_FRAC - OUT_FRAC_BITS);
	localparam logic [SHIFT_W-1:0] SH_LT    = SHIFT_W'(X_FRAC - LT_FRAC);
	localparam logic signed [VAL_W-1:0] VAL_HI = VAL_MAX[VAL_W-1:0];
	localparam logic signed [VAL_W-1:0] VAL_LO = VAL_MIN[VAL_W-1:0];

	function automatic ucode_t uop(a_sel_t a, b_sel_t b, logic [SHIFT_W-1:0] s,
			dst_t d, base_t bs, step_t n);
		uop = '{a_sel: a, b_sel: b, shift: s, dst: d, base: bs, nxt: n};
	endfunction

	coef_t              coef;
	mul_req_t           req;
	mul_rsp_t           rsp;
	ucode_t             uc;

	state_t             state_q;
	step_t              step_q;
	logic               out_valid_q;
	out_item_t          out_data_q;
	logic [LT_W-1:0]    lt_q;

	logic               op_q;
	logic [RAW_W-1:0]   raw_q;
	logic [D_W-1:0]     d_q;
	logic [WORD_W-1:0]  w_q;
	logic [WORD_W-1:0]  k_q;
	logic [WORD_W-1:0]  acc_q;
	logic [WORD_W-1:0]  tsq_q;
	logic [WORD_W-1:0]  tcu_q;

	logic               in_acc;
	logic               out_free;
	logic               wb_en;
	logic [WORD_W-1:0]  l_ext;
	logic [WORD_W-1:0]  op_a;
	logic [WORD_W-1:0]  op_b;
	logic [WORD_W-1:0]  base_v;
	logic [WORD_W-1:0]  wb;
	logic               sat_hi;
	logic               sat_lo;

	btpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	btpc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign wb_en     = (state_q == ST_WAIT) && rsp.done;
	assign l_ext     = {{(WORD_W-LT_W){lt_q[LT_W-1]}}, lt_q};

	// microcode: operands, rounding shift, destination, its starting value and the next step
	always_comb begin
		unique case (step_q)
			S_T_DT3:  uc = uop(A_D,   B_T3,  6'd0,     DST_W,   BASE_T2,   S_T_X);
			S_T_X:    uc = uop(A_D,   B_W,   6'd0,     DST_K,   BASE_ZERO, S_T_LT);
			S_T_LT:   uc = uop(A_K,   B_ONE, SH_LT,    DST_LT,  BASE_ZERO, S_T_OUT);
			S_T_OUT:  uc = uop(A_K,   B_ONE, SH_T_OUT, DST_RES, BASE_ZERO, S_T_DT3);
			S_P_TSQ:  uc = uop(A_L,   B_L,   6'd36,    DST_TSQ, BASE_ZERO, S_P_TCU);
			S_P_TCU:  uc = uop(A_TSQ, B_L,   6'd44,    DST_TCU, BASE_ZERO, S_P_OFF6);
			S_P_OFF6: uc = uop(A_P6,  B_L,   6'd10,    DST_ACC, BASE_P5,   S_P_OFF7);
			S_P_OFF7: uc = uop(A_P7,  B_TSQ, 6'd12,    DST_ACC, BASE_DST,  S_P_OFF8);
			S_P_OFF8: uc = uop(A_P8,  B_TCU, 6'd11,    DST_ACC, BASE_DST,  S_P_LIN2);
			S_P_LIN2: uc = uop(A_P2M, B_L,   6'd9,     DST_K,   BASE_P1,   S_P_LIN3);
			S_P_LIN3: uc = uop(A_P3,  B_TSQ, 6'd12,    DST_K,   BASE_DST,  S_P_LIN4);
			S_P_LIN4: uc = uop(A_P4,  B_TCU, 6'd9,     DST_K,   BASE_DST,  S_P_KRAW);
			S_P_KRAW: uc = uop(A_K,   B_RAW, 6'd24,    DST_ACC, BASE_DST,  S_P_Q2);
			S_P_Q2:   uc = uop(A_P10, B_L,   6'd0,     DST_K,   BASE_P9,   S_P_RSQ);
			S_P_RSQ:  uc = uop(A_RAW, B_RAW, 6'd0,     DST_W,   BASE_ZERO, S_P_SQR);
			S_P_SQR:  uc = uop(A_K,   B_W,   6'd52,    DST_ACC, BASE_DST,  S_P_CUB1);
			S_P_CUB1: uc = uop(A_P11, B_W,   6'd0,     DST_W,   BASE_ZERO, S_P_CUB2);
			S_P_CUB2: uc = uop(A_W,   B_RAW, 6'd33,    DST_ACC, BASE_DST,  S_P_OUT);
			S_P_OUT:  uc = uop(A_ACC, B_ONE, SH_P_OUT, DST_RES, BASE_ZERO, S_T_DT3);
			default:  uc = uop(A_K,   B_ONE, SH_T_OUT, DST_RES, BASE_ZERO, S_T_DT3);
		endcase
	end

	always_comb begin
		case (uc.a_sel)
			A_D:     op_a = {{(WORD_W-D_W){d_q[D_W-1]}}, d_q};
			A_K:     op_a = k_q;
			A_L:     op_a = l_ext;
			A_TSQ:   op_a = tsq_q;
			A_P6:    op_a = {48'b0, coef.p6};
			A_P7:    op_a = {{56{coef.p7[7]}}, coef.p7};
			A_P8:    op_a = {{56{coef.p8[7]}}, coef.p8};
			A_P2M:   op_a = {{48{coef.p2[15]}}, coef.p2} - P_BIAS;
			A_P3:    op_a = {{56{coef.p3[7]}}, coef.p3};
			A_P4:    op_a = {{56{coef.p4[7]}}, coef.p4};
			A_P10:   op_a = {{56{coef.p10[7]}}, coef.p10};
			A_RAW:   op_a = {{(WORD_W-RAW_W){1'b0}}, raw_q};
			A_P11:   op_a = {{56{coef.p11[7]}}, coef.p11};
			A_W:     op_a = w_q;
			A_ACC:   op_a = acc_q;
			default: op_a = '0;
		endcase
		case (uc.b_sel)
			B_T3:    op_b = {{56{coef.t3[7]}}, coef.t3};
			B_W:     op_b = w_q;
			B_ONE:   op_b = 64'd1;
			B_L:     op_b = l_ext;
			B_TSQ:   op_b = tsq_q;
			B_TCU:   op_b = tcu_q;
			B_RAW:   op_b = {{(WORD_W-RAW_W){1'b0}}, raw_q};
			default: op_b = '0;
		endcase
	end

	// the last step waits until the output register is free
	assign req.start = (state_q == ST_ISSUE) && (uc.dst != DST_RES || out_free);
	assign req.neg   = op_a[WORD_W-1] ^ op_b[WORD_W-1];
	assign req.shift = uc.shift;
	assign req.a_mag = op_a[WORD_W-1] ? -op_a : op_a;
	assign req.b_mag = op_b[WORD_W-1] ? -op_b : op_b;

	always_comb begin
		case (uc.base)
			BASE_DST: begin
				case (uc.dst)
					DST_W:   base_v = w_q;
					DST_K:   base_v = k_q;
					DST_ACC: base_v = acc_q;
					DST_TSQ: base_v = tsq_q;
					DST_TCU: base_v = tcu_q;
					DST_LT:  base_v = l_ext;
					default: base_v = '0;
				endcase
			end
			BASE_T2:   base_v = {48'b0, coef.t2} << 18;
			BASE_P5:   base_v = {48'b0, coef.p5} << (ACC_FRAC + 3);
			BASE_P1:   base_v = ({{48{coef.p1[15]}}, coef.p1} - P_BIAS) << LT_FRAC;
			BASE_P9:   base_v = {{48{coef.p9[15]}}, coef.p9} << LT_FRAC;
			default:   base_v = '0;
		endcase
	end

	assign wb     = rsp.neg ? (base_v - rsp.mag) : (base_v + rsp.mag);
	assign sat_hi = $signed(wb) > VAL_MAX;
	assign sat_lo = $signed(wb) < VAL_MIN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= S_T_DT3;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						step_q  <= (in_data.operation == OP_PRES) ? S_P_TSQ : S_T_DT3;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (req.start) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (rsp.done) begin
						if (uc.dst == DST_RES) begin
							state_q                 <= ST_IDLE;
							out_valid_q             <= 1'b1;
							out_data_q.result_kind  <= op_q;
							out_data_q.saturated    <= sat_hi || sat_lo;
							out_data_q.result_value <= sat_hi ? VAL_HI :
								sat_lo ? VAL_LO : wb[VAL_W-1:0];
						end else begin
							step_q  <= uc.nxt;
							state_q <= ST_ISSUE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= '0;
		end else if (wb_en && uc.dst == DST_LT) begin
			lt_q <= wb[LT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= in_data.operation;
			raw_q <= in_data.raw_sample;
			d_q   <= {1'b0, in_data.raw_sample} - {1'b0, coef.t1, 8'b0};
		end
		if (wb_en) begin
			case (uc.dst)
				DST_W:   w_q   <= wb;
				DST_K:   k_q   <= wb;
				DST_ACC: acc_q <= wb;
				DST_TSQ: tsq_q <= wb;
				DST_TCU: tcu_q <= wb;
				default: begin
				end
			endcase
		end
	end

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.saturated) |->
			(out_data.result_value == VAL_HI || out_data.result_value == VAL_LO))
		else $error("saturated result not at a bound");

	a_temp_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.result_kind == OP_TEMP) |-> !out_data.saturated)
		else $error("temperature result saturated");

	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (state_q == ST_WAIT))
		else $error("multiplier finished with no product pending");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_WAIT && rsp.done))
		else $error("result appeared without a final product");

endmodule

`default_nettype wire
